// ===== src/bspwm_pkg.sv =====
// Shared types and constants of the button stepped fast PWM block.
`default_nettype none

package bspwm_pkg;

    // Field and register widths
    localparam int TOP_W      = 16;
    localparam int RATIO_W    = 11;
    localparam int DUTY_W     = 7;
    localparam int PRE_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_VALUE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_RATIO = 1'd1;

    // Register reset values
    localparam logic [TOP_W-1:0]   TOP_RESET   = 16'd15625;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 11'd1024;

    // Duty stepping
    localparam logic [DUTY_W-1:0] DUTY_STEP      = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MIN       = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX       = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_INC_LIMIT = 7'd90;
    localparam logic [DUTY_W-1:0] DUTY_DEC_LIMIT = 7'd20;

    // Prescaler limit
    localparam logic [RATIO_W-1:0] PRESCALE_MAX = 11'd1024;

    // Divide by 100 through a reciprocal: q = (p * ceil(2^30 / 100)) >> 30,
    // exact for every product below 2^23.
    localparam int PROD_W       = TOP_W + DUTY_W;
    localparam int RECIP_W      = 24;
    localparam int RECIP_SHIFT  = 30;
    localparam int RECIP_PROD_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = 24'd10737419;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // One classified word: duty after the button check and its compare value
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [TOP_W-1:0]  cmp;
    } t_work;

    // Read side of the work queue
    typedef struct packed {
        logic  valid;
        t_work work;
    } t_q_rd;

endpackage

`default_nettype wire

// ===== src/bspwm_in_if.sv =====
// Input channel: button levels and sample flag with valid/ready.
`default_nettype none

interface bspwm_in_if;
    logic valid;
    logic ready;
    logic inc_level;
    logic dec_level;
    logic sample;

    modport source (output valid, output inc_level, output dec_level, output sample,
                    input ready);
    modport sink   (input valid, input inc_level, input dec_level, input sample,
                    output ready);
endinterface

`default_nettype wire

// ===== src/bspwm_out_if.sv =====
// Output channel: PWM level, duty and compare with valid/ready.
`default_nettype none

interface bspwm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          pwm_out;
    logic [bspwm_pkg::DUTY_W-1:0]  duty_percent;
    logic [bspwm_pkg::TOP_W-1:0]   compare_value;

    modport source (output valid, output pwm_out, output duty_percent,
                    output compare_value, input ready);
    modport sink   (input valid, input pwm_out, input duty_percent,
                    input compare_value, output ready);
endinterface

`default_nettype wire

// ===== src/bspwm_front.sv =====
// Front end: button edge check, duty update and compare value pipeline.
`default_nettype none

module bspwm_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  wire                             i_inc_level,
    input  wire                             i_dec_level,
    input  wire                             i_sample,
    input  wire [bspwm_pkg::TOP_W-1:0]      i_top_value,
    input  wire [bspwm_pkg::Q_CNT_W-1:0]    i_q_count,
    output logic                            o_ready,
    output logic                            o_push,
    output bspwm_pkg::t_work                o_work
);

    logic                               r_last_inc;
    logic                               r_last_dec;
    logic [bspwm_pkg::DUTY_W-1:0]       r_duty;
    logic                               n_last_inc;
    logic                               n_last_dec;
    logic [bspwm_pkg::DUTY_W-1:0]       n_duty;

    logic                               r_s1_valid;
    logic [bspwm_pkg::DUTY_W-1:0]       r_s1_duty;
    logic [bspwm_pkg::PROD_W-1:0]       r_s1_prod;
    logic [bspwm_pkg::PROD_W-1:0]       n_s1_prod;

    logic                               r_s2_valid;
    logic [bspwm_pkg::DUTY_W-1:0]       r_s2_duty;
    logic [bspwm_pkg::TOP_W-1:0]        r_s2_cmp;
    logic [bspwm_pkg::RECIP_PROD_W-1:0] s2_wide;

    logic [bspwm_pkg::Q_CNT_W:0]        in_flight;
    logic                               accept;
    logic                               fall_inc;
    logic                               fall_dec;

    // Take a word only while the queue has room for everything in flight
    assign in_flight = {1'b0, i_q_count}
                     + {{bspwm_pkg::Q_CNT_W{1'b0}}, r_s1_valid}
                     + {{bspwm_pkg::Q_CNT_W{1'b0}}, r_s2_valid};
    assign o_ready   = in_flight < (bspwm_pkg::Q_CNT_W + 1)'(bspwm_pkg::QUEUE_DEPTH);
    assign accept    = i_valid & o_ready;

    // Detect sampled falling edges; increase wins over decrease
    assign fall_inc = r_last_inc & ~i_inc_level;
    assign fall_dec = r_last_dec & ~i_dec_level;

    always_comb begin
        n_duty     = r_duty;
        n_last_inc = r_last_inc;
        n_last_dec = r_last_dec;
        if (accept && i_sample) begin
            if (fall_inc) begin
                if (r_duty <= bspwm_pkg::DUTY_INC_LIMIT) begin
                    n_duty = r_duty + bspwm_pkg::DUTY_STEP;
                end
            end else if (fall_dec) begin
                if (r_duty >= bspwm_pkg::DUTY_DEC_LIMIT) begin
                    n_duty = r_duty - bspwm_pkg::DUTY_STEP;
                end
            end
            n_last_inc = i_inc_level;
            n_last_dec = i_dec_level;
        end
    end

    // Form top * duty, then divide by 100 through the reciprocal
    assign n_s1_prod = bspwm_pkg::PROD_W'(i_top_value) * bspwm_pkg::PROD_W'(n_duty);
    assign s2_wide   = bspwm_pkg::RECIP_PROD_W'(r_s1_prod)
                     * bspwm_pkg::RECIP_PROD_W'(bspwm_pkg::RECIP_K);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty     <= bspwm_pkg::DUTY_MIN;
            r_last_inc <= 1'b1;
            r_last_dec <= 1'b1;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_duty     <= n_duty;
            r_last_inc <= n_last_inc;
            r_last_dec <= n_last_dec;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_duty <= n_duty;
        r_s1_prod <= n_s1_prod;
        r_s2_duty <= r_s1_duty;
        r_s2_cmp  <= s2_wide[bspwm_pkg::RECIP_SHIFT +: bspwm_pkg::TOP_W];
    end

    assign o_push      = r_s2_valid;
    assign o_work.duty = r_s2_duty;
    assign o_work.cmp  = r_s2_cmp;

    // The compare never exceeds the period top
    a_cmp_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_cmp <= i_top_value))
        else $error("compare value above top");

    // Duty always stays on its allowed range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_duty >= bspwm_pkg::DUTY_MIN && r_duty <= bspwm_pkg::DUTY_MAX))
        else $error("duty out of range");

endmodule

`default_nettype wire

// ===== src/bspwm_queue.sv =====
// Short work queue between the front end and the timer back end.
`default_nettype none

module bspwm_queue (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push,
    input  wire bspwm_pkg::t_work          i_work,
    input  wire                            i_pop_ready,
    output bspwm_pkg::t_q_rd               o_rd,
    output logic [bspwm_pkg::Q_CNT_W-1:0]  o_count
);

    bspwm_pkg::t_work                  r_mem [bspwm_pkg::QUEUE_DEPTH];
    logic [bspwm_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [bspwm_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [bspwm_pkg::Q_CNT_W-1:0]     r_count;
    logic [bspwm_pkg::Q_CNT_W-1:0]     n_count;
    logic                              pop;

    assign o_rd.valid = (r_count != '0);
    assign o_rd.work  = r_mem[r_rd_ptr];
    assign o_count    = r_count;
    assign pop        = o_rd.valid & i_pop_ready;

    // Track occupancy
    always_comb begin
        case ({i_push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    // The front end's credit check keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_count < bspwm_pkg::Q_CNT_W'(bspwm_pkg::QUEUE_DEPTH)))
        else $error("work queue overflow");

endmodule

`default_nettype wire

// ===== src/bspwm_back.sv =====
// Back end: prescaler, timer, compare reload and registered result word.
`default_nettype none

module bspwm_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [bspwm_pkg::TOP_W-1:0]      i_top_value,
    input  wire [bspwm_pkg::RATIO_W-1:0]    i_prescale_ratio,
    input  wire bspwm_pkg::t_q_rd           i_rd,
    output logic                            o_pop_ready,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic                            o_pwm_out,
    output logic [bspwm_pkg::DUTY_W-1:0]    o_duty_percent,
    output logic [bspwm_pkg::TOP_W-1:0]     o_compare_value
);

    localparam int WIDE_W = COUNT_WIDTH + bspwm_pkg::TOP_W;

    logic [bspwm_pkg::PRE_W-1:0]    r_pre_cnt;
    logic [COUNT_WIDTH-1:0]         r_timer;
    logic [bspwm_pkg::TOP_W-1:0]    r_active;
    logic [bspwm_pkg::PRE_W-1:0]    n_pre_cnt;
    logic [COUNT_WIDTH-1:0]         n_timer;
    logic [bspwm_pkg::TOP_W-1:0]    n_active;

    logic                           r_out_valid;
    logic                           r_pwm;
    logic [bspwm_pkg::DUTY_W-1:0]   r_duty;
    logic [bspwm_pkg::TOP_W-1:0]    r_cmp;

    logic [bspwm_pkg::RATIO_W-1:0]  ratio_eff;
    logic [bspwm_pkg::RATIO_W-1:0]  pre_sum;
    logic                           pre_hit;
    logic [WIDE_W-1:0]              top_wide;
    logic [COUNT_WIDTH-1:0]         top_eff;
    logic                           take;
    logic                           n_pwm;

    // Take a word when the result register is free or being drained
    assign o_pop_ready = ~r_out_valid | i_ready;
    assign take        = i_rd.valid & o_pop_ready;

    // Clamp the ratio to 1..1024
    always_comb begin
        if (i_prescale_ratio == '0) begin
            ratio_eff = bspwm_pkg::RATIO_W'(1);
        end else if (i_prescale_ratio > bspwm_pkg::PRESCALE_MAX) begin
            ratio_eff = bspwm_pkg::PRESCALE_MAX;
        end else begin
            ratio_eff = i_prescale_ratio;
        end
    end

    assign pre_sum  = {1'b0, r_pre_cnt} + bspwm_pkg::RATIO_W'(1);
    assign pre_hit  = pre_sum >= ratio_eff;
    assign top_wide = WIDE_W'(i_top_value);
    assign top_eff  = top_wide[COUNT_WIDTH-1:0];

    // Advance prescaler and timer; reload the compare at the bottom
    always_comb begin
        n_pre_cnt = r_pre_cnt;
        n_timer   = r_timer;
        n_active  = r_active;
        if (pre_hit) begin
            n_pre_cnt = '0;
            if (r_timer >= top_eff) begin
                n_timer  = '0;
                n_active = i_rd.work.cmp;
            end else begin
                n_timer = r_timer + COUNT_WIDTH'(1);
            end
        end else begin
            n_pre_cnt = pre_sum[bspwm_pkg::PRE_W-1:0];
        end
        n_pwm = WIDE_W'(n_timer) <= WIDE_W'(n_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cnt   <= '0;
            r_timer     <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pre_cnt <= n_pre_cnt;
                r_timer   <= n_timer;
                r_active  <= n_active;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pwm  <= n_pwm;
            r_duty <= i_rd.work.duty;
            r_cmp  <= n_active;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pwm_out       = r_pwm;
    assign o_duty_percent  = r_duty;
    assign o_compare_value = r_cmp;

    // The word shows the compare in effect after its tick
    a_cmp_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_cmp == r_active))
        else $error("result compare differs from active compare");

endmodule

`default_nettype wire

// ===== src/button_stepped_fast_pwm_core.sv =====
// Top level of the button stepped fast PWM block.
//
// Each input word is one system clock tick carrying two active-low button
// levels and a sample flag; each produces exactly one result word with the
// PWM level, the duty in percent and the compare value in effect. The block
// takes one word per clock while ready is high; each word passes the two
// front stages and the queue to the output register. The front end checks
// the buttons and forms top*duty/100 over two stages (one multiply each); a
// four-entry queue feeds the back end, whose prescaler and timer step once
// per word and whose output register takes the next word in the same cycle
// a waiting result drains. While results are held off the back end stalls,
// the queue fills, and the input stalls once four words sit in the front
// stages and the queue. Configuration writes take effect at once and belong
// to idle periods. No clearing pass after reset.
`default_nettype none

module button_stepped_fast_pwm_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [bspwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [bspwm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bspwm_in_if.sink                           i_in,
    bspwm_out_if.source                        o_out
);

    logic [bspwm_pkg::TOP_W-1:0]    r_top_value;
    logic [bspwm_pkg::RATIO_W-1:0]  r_prescale_ratio;

    logic                           push;
    bspwm_pkg::t_work               push_work;
    bspwm_pkg::t_q_rd               q_rd;
    logic [bspwm_pkg::Q_CNT_W-1:0]  q_count;
    logic                           pop_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_value      <= bspwm_pkg::TOP_RESET;
            r_prescale_ratio <= bspwm_pkg::RATIO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bspwm_pkg::CFG_TOP_VALUE: begin
                    r_top_value <= i_cfg_data;
                end
                bspwm_pkg::CFG_PRESCALE_RATIO: begin
                    r_prescale_ratio <= i_cfg_data[bspwm_pkg::RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bspwm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_inc_level (i_in.inc_level),
        .i_dec_level (i_in.dec_level),
        .i_sample    (i_in.sample),
        .i_top_value (r_top_value),
        .i_q_count   (q_count),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_work      (push_work)
    );

    bspwm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_work      (push_work),
        .i_pop_ready (pop_ready),
        .o_rd        (q_rd),
        .o_count     (q_count)
    );

    bspwm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_top_value      (r_top_value),
        .i_prescale_ratio (r_prescale_ratio),
        .i_rd             (q_rd),
        .o_pop_ready      (pop_ready),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_pwm_out        (o_out.pwm_out),
        .o_duty_percent   (o_out.duty_percent),
        .o_compare_value  (o_out.compare_value)
    );

endmodule

`default_nettype wire

// ===== tb/button_stepped_fast_pwm_core_checker.sv =====
// Scoreboard for the button stepped fast PWM core: predicts every result word and compares it.
`timescale 1ns / 1ps

module button_stepped_fast_pwm_core_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [bspwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [bspwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bspwm_in_if                             i_in,
    bspwm_out_if                            i_out,
    output int                              o_mismatches,
    output int                              o_pending
);

    localparam int PERCENT    = 100;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                         pwm;
        logic [bspwm_pkg::DUTY_W-1:0] duty;
        logic [bspwm_pkg::TOP_W-1:0]  cmp;
    } t_pwm_word;

    // Shadow of the configuration and of the timer state
    logic [bspwm_pkg::TOP_W-1:0]   top_reg;
    logic [bspwm_pkg::RATIO_W-1:0] ratio_reg;
    logic [bspwm_pkg::PRE_W-1:0]   pre_cnt;
    logic [COUNT_WIDTH-1:0]        timer_cnt;
    logic [bspwm_pkg::TOP_W-1:0]   active_cmp;
    logic [bspwm_pkg::DUTY_W-1:0]  duty_reg;
    logic                          last_inc;
    logic                          last_dec;

    t_pwm_word expected_words[$];
    int        mismatches = 0;

    // Advance the shadow timer by one tick and form the word it shows
    function automatic t_pwm_word pwm_tick(input logic inc, input logic dec, input logic smp);
        logic [bspwm_pkg::RATIO_W-1:0] ratio;
        logic [COUNT_WIDTH-1:0]        top_cnt;
        logic [bspwm_pkg::PROD_W-1:0]  prod;
        t_pwm_word                     w;
        // Buttons first: a sampled falling edge steps the duty, button one wins
        if (smp) begin
            if (last_inc && !inc) begin
                if (duty_reg <= bspwm_pkg::DUTY_INC_LIMIT)
                    duty_reg = duty_reg + bspwm_pkg::DUTY_STEP;
            end else if (last_dec && !dec) begin
                if (duty_reg >= bspwm_pkg::DUTY_DEC_LIMIT)
                    duty_reg = duty_reg - bspwm_pkg::DUTY_STEP;
            end
            last_inc = inc;
            last_dec = dec;
        end
        // Clamp the ratio to 1..1024
        ratio = ratio_reg;
        if (ratio == '0)
            ratio = bspwm_pkg::RATIO_W'(1);
        if (ratio > bspwm_pkg::PRESCALE_MAX)
            ratio = bspwm_pkg::PRESCALE_MAX;
        // Prescaler, then the timer; reload the compare at the bottom
        if ({1'b0, pre_cnt} + 1 >= ratio) begin
            pre_cnt = '0;
            top_cnt = COUNT_WIDTH'(top_reg);
            if (timer_cnt >= top_cnt) begin
                timer_cnt  = '0;
                prod       = top_reg * duty_reg;
                active_cmp = bspwm_pkg::TOP_W'(prod / PERCENT);
            end else begin
                timer_cnt = timer_cnt + 1'b1;
            end
        end else begin
            pre_cnt = pre_cnt + 1'b1;
        end
        w.pwm  = (timer_cnt <= active_cmp);
        w.duty = duty_reg;
        w.cmp  = active_cmp;
        return w;
    endfunction

    // Track config writes, check result words, queue predictions
    always @(posedge i_clk) begin
        t_pwm_word got;
        t_pwm_word want;
        if (!i_rst_n) begin
            top_reg    = bspwm_pkg::TOP_RESET;
            ratio_reg  = bspwm_pkg::RATIO_RESET;
            pre_cnt    = '0;
            timer_cnt  = '0;
            active_cmp = '0;
            duty_reg   = bspwm_pkg::DUTY_MIN;
            last_inc   = 1'b1;
            last_dec   = 1'b1;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bspwm_pkg::CFG_TOP_VALUE:
                        top_reg = i_cfg_data[bspwm_pkg::TOP_W-1:0];
                    bspwm_pkg::CFG_PRESCALE_RATIO:
                        ratio_reg = i_cfg_data[bspwm_pkg::RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.pwm  = i_out.pwm_out;
                got.duty = i_out.duty_percent;
                got.cmp  = i_out.compare_value;
                if (expected_words.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: unexpected result word pwm=%0b duty=%0d cmp=%0d",
                                 $time, got.pwm, got.duty, got.cmp);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.pwm !== want.pwm || got.duty !== want.duty ||
                        got.cmp !== want.cmp) begin
                        if (mismatches < REPORT_MAX)
                            $display({"%0t: mismatch exp pwm=%0b duty=%0d cmp=%0d,",
                                      " got pwm=%0b duty=%0d cmp=%0d"},
                                     $time, want.pwm, want.duty, want.cmp,
                                     got.pwm, got.duty, got.cmp);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_words.push_back(pwm_tick(i_in.inc_level, i_in.dec_level, i_in.sample));
        end
        o_pending    <= expected_words.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/button_stepped_fast_pwm_core_tb.sv =====
// Stimulus and verdict for the button stepped fast PWM core.
`timescale 1ns / 1ps

module button_stepped_fast_pwm_core_tb;

    localparam int COUNT_WIDTH    = 16;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {BIAS_NONE, BIAS_INC, BIAS_DEC} t_press_bias;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [bspwm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bspwm_pkg::CFG_DATA_W-1:0] cfg_data;

    bspwm_in_if  in_if ();
    bspwm_out_if out_if ();

    int   mismatches;
    int   pending;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    int   quiet_cycles = 0;
    logic btn_inc = 1'b1;
    logic btn_dec = 1'b1;

    button_stepped_fast_pwm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    button_stepped_fast_pwm_core_checker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Drive ready: random stalls, plus a long hold-off on request
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Abort when no word moves on either channel for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("button_stepped_fast_pwm_core_tb: FAIL");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic inc, input logic dec, input logic smp);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_if.valid     <= 1'b1;
        in_if.inc_level <= inc;
        in_if.dec_level <= dec;
        in_if.sample    <= smp;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Hold the input idle until every predicted word has come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write both registers back to back
    task automatic set_config(input logic [bspwm_pkg::CFG_DATA_W-1:0] top,
                              input logic [bspwm_pkg::CFG_DATA_W-1:0] ratio_data);
        cfg_we   <= 1'b1;
        cfg_idx  <= bspwm_pkg::CFG_TOP_VALUE;
        cfg_data <= top;
        @(posedge i_clk);
        cfg_idx  <= bspwm_pkg::CFG_PRESCALE_RATIO;
        cfg_data <= ratio_data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly press/release toggling, optionally biased to one button, some pure noise
    task automatic send_button_word(input t_press_bias bias);
        int p_inc;
        int p_dec;
        if ($urandom_range(0, 9) < 2) begin
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
            case (bias)
                BIAS_INC: begin
                    p_inc = 50;
                    p_dec = 10;
                end
                BIAS_DEC: begin
                    p_inc = 10;
                    p_dec = 50;
                end
                default: begin
                    p_inc = 30;
                    p_dec = 30;
                end
            endcase
            if ($urandom_range(0, 99) < p_inc)
                btn_inc = ~btn_inc;
            if ($urandom_range(0, 99) < p_dec)
                btn_dec = ~btn_dec;
            send_word(btn_inc, btn_dec, $urandom_range(0, 3) != 0);
        end
    endtask

    // Drain, reconfigure, then stream random words
    task automatic run_phase(input logic [bspwm_pkg::CFG_DATA_W-1:0] top,
                             input logic [bspwm_pkg::CFG_DATA_W-1:0] ratio_data,
                             input int n, input int idle, input int stall,
                             input t_press_bias bias, input bit hold);
        wait_drained();
        set_config(top, ratio_data);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if (hold && i == n / 4)
                hold_req <= ~hold_req;
            send_button_word(bias);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= bspwm_pkg::CFG_TOP_VALUE;
        cfg_data        <= '0;
        in_if.valid     <= 1'b0;
        in_if.inc_level <= 1'b1;
        in_if.dec_level <= 1'b1;
        in_if.sample    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: idle, unsampled level, one press
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b0, 1'b1, 1'b1);

        // Short period so compare reloads are visible
        wait_drained();
        set_config(16'd4, 16'd1);
        send_word(1'b1, 1'b1, 1'b1);
        // Both pressed without a sample: ignored
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);
        // Both fall together: increase wins
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        // Step down to the floor and once past it
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b1, 1'b0, 1'b1);
        // Increase falls while decrease is held, then both held
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b0, 1'b0, 1'b1);
        // Release without a sample keeps the old levels, so no new edge
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b1, 1'b1);

        // Random phases over settings and idling patterns
        run_phase(16'd4, 16'd1, 90, 0, 0, BIAS_INC, 1'b0);
        // Zero top, zero ratio (upper data bits set, ignored)
        run_phase(16'd0, 16'hF800, 70, 83, 0, BIAS_NONE, 1'b0);
        // Full top, ratio above the saturation point
        run_phase(16'hFFFF, 16'h07FF, 60, 0, 83, BIAS_DEC, 1'b0);
        run_phase(16'd300, 16'd1, 120, 22, 22, BIAS_DEC, 1'b0);
        // Top lowered below the running count; long receiver hold-off
        run_phase(16'd3, 16'd3, 80, 0, 0, BIAS_INC, 1'b1);
        run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 5)), 80,
                  $urandom_range(0, 83), $urandom_range(0, 83), BIAS_NONE, 1'b0);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 60,
                  22, 22, BIAS_NONE, 1'b0);
        run_phase(16'd1, 16'd1024, 20, 0, 0, BIAS_DEC, 1'b0);
        run_phase(16'd1, 16'd2, 40, 22, 22, BIAS_NONE, 1'b0);

        // Let the pipeline settle and give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("button_stepped_fast_pwm_core_tb: PASS");
        else
            $display("button_stepped_fast_pwm_core_tb: FAIL");
        $finish;
    end

endmodule
